@@ src/utf8m_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8m_pkg
// Shared types, constants and lookup functions of the UTF-8 RTL majority
// detector: length offsets, the right-to-left range list, stage words.
// ----------------------------------------------------------------------------
package utf8m_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int OUT_BITS    = 16;
	localparam int RANGE_COUNT = 66;

	localparam logic [2:0] LEN_MAX = 3'd6;

	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
	} rng_t;

	localparam rng_t RTL_RANGES [RANGE_COUNT] = '{
		'{32'h000005BE, 32'h000005BE}, '{32'h000005C0, 32'h000005C0},
		'{32'h000005C3, 32'h000005C3}, '{32'h000005C6, 32'h000005C6},
		'{32'h000005D0, 32'h000005EA}, '{32'h000005F0, 32'h000005F4},
		'{32'h00000608, 32'h00000608}, '{32'h0000060B, 32'h0000060B},
		'{32'h0000060D, 32'h0000060D}, '{32'h0000061B, 32'h0000061B},
		'{32'h0000061E, 32'h0000064A}, '{32'h0000066D, 32'h0000066F},
		'{32'h00000671, 32'h000006D5}, '{32'h000006E5, 32'h000006E6},
		'{32'h000006EE, 32'h000006EF}, '{32'h000006FA, 32'h0000070D},
		'{32'h00000710, 32'h00000710}, '{32'h00000712, 32'h0000072F},
		'{32'h0000074D, 32'h000007A5}, '{32'h000007B1, 32'h000007B1},
		'{32'h000007C0, 32'h000007EA}, '{32'h000007F4, 32'h000007F5},
		'{32'h000007FA, 32'h000007FA}, '{32'h00000800, 32'h00000815},
		'{32'h0000081A, 32'h0000081A}, '{32'h00000824, 32'h00000824},
		'{32'h00000828, 32'h00000828}, '{32'h00000830, 32'h0000083E},
		'{32'h00000840, 32'h00000858}, '{32'h0000085E, 32'h0000085E},
		'{32'h0000200F, 32'h0000200F}, '{32'h0000FB1D, 32'h0000FB1D},
		'{32'h0000FB1F, 32'h0000FB28}, '{32'h0000FB2A, 32'h0000FB36},
		'{32'h0000FB38, 32'h0000FB3C}, '{32'h0000FB3E, 32'h0000FB3E},
		'{32'h0000FB40, 32'h0000FB41}, '{32'h0000FB43, 32'h0000FB44},
		'{32'h0000FB46, 32'h0000FBC1}, '{32'h0000FBD3, 32'h0000FD3D},
		'{32'h0000FD50, 32'h0000FD8F}, '{32'h0000FD92, 32'h0000FDC7},
		'{32'h0000FDF0, 32'h0000FDFC}, '{32'h0000FE70, 32'h0000FE74},
		'{32'h0000FE76, 32'h0000FEFC}, '{32'h00010800, 32'h00010805},
		'{32'h00010808, 32'h00010808}, '{32'h0001080A, 32'h00010835},
		'{32'h00010837, 32'h00010838}, '{32'h0001083C, 32'h0001083C},
		'{32'h0001083F, 32'h00010855}, '{32'h00010857, 32'h0001085F},
		'{32'h00010900, 32'h0001091B}, '{32'h00010920, 32'h00010939},
		'{32'h0001093F, 32'h0001093F}, '{32'h00010A00, 32'h00010A00},
		'{32'h00010A10, 32'h00010A13}, '{32'h00010A15, 32'h00010A17},
		'{32'h00010A19, 32'h00010A33}, '{32'h00010A40, 32'h00010A47},
		'{32'h00010A50, 32'h00010A58}, '{32'h00010A60, 32'h00010A7F},
		'{32'h00010B00, 32'h00010B35}, '{32'h00010B40, 32'h00010B55},
		'{32'h00010B58, 32'h00010B72}, '{32'h00010B78, 32'h00010B7F}
	};

	// decoder -> classifier word
	typedef struct packed {
		logic [31:0] cp_a;
		logic        ok_a;
		logic [31:0] cp_b;
		logic        ok_b;
		logic        last;
	} dec_t;

	// classifier -> tally word
	typedef struct packed {
		logic ok_a;
		logic rtl_a;
		logic ok_b;
		logic rtl_b;
		logic last;
	} cls_t;

	function automatic logic [31:0] len_offset(input logic [2:0] len);
		logic [31:0] off;
		unique case (len)
			3'd2:    off = 32'h00003080;
			3'd3:    off = 32'h000E2080;
			3'd4:    off = 32'h03C82080;
			3'd5:    off = 32'hFA082080;
			3'd6:    off = 32'h82082080;
			default: off = 32'h00000000;
		endcase
		return off;
	endfunction

	function automatic logic in_rtl(input logic [31:0] cp);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < RANGE_COUNT; k++) begin
			if (cp >= RTL_RANGES[k].lo && cp <= RTL_RANGES[k].hi)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

@@ src/utf8m_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8m_decode
// Input register and code point assembly. Emits up to two finished code
// points per word: the one closed by this byte and, on last, the final one.
// ----------------------------------------------------------------------------
module utf8m_decode
	import utf8m_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic       dec_ready,
	output logic       dec_valid,
	output dec_t       dec_word
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        ready_s1;
	logic        fire_s1;

	logic [31:0] acc_q;
	logic [2:0]  len_q;
	logic        pend_q;
	logic        stop_q;

	logic [31:0] acc_n;
	logic [2:0]  len_n;
	logic        pend_n;
	logic        stop_n;

	logic [31:0] off_a;
	logic [31:0] cp_a;
	logic [31:0] cp_b;
	logic        cont;
	logic        fin_a;
	logic        zero_a;
	logic        stop_mid;
	logic        fin_b;

	assign ready_s1   = !valid_s1 || dec_ready;
	assign byte_stall = !ready_s1;
	assign fire_s1    = valid_s1 && dec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && byte_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	always_comb begin
		off_a    = len_offset(len_q);
		cp_a     = acc_q - off_a;
		zero_a   = (acc_q == off_a);
		cont     = pend_q && ((byte_s1 & CONT_MASK) == CONT_TAG);
		fin_a    = !stop_q && pend_q && !cont;
		stop_mid = stop_q || (fin_a && zero_a);

		acc_n  = acc_q;
		len_n  = len_q;
		pend_n = pend_q;
		stop_n = stop_q;
		if (!stop_q && cont) begin
			acc_n = {acc_q[25:0], 6'b0} + {24'b0, byte_s1};
			if (len_q < LEN_MAX)
				len_n = len_q + 3'd1;
		end else begin
			if (fin_a)
				pend_n = 1'b0;
			if (fin_a && zero_a)
				stop_n = 1'b1;
			if (!stop_mid) begin
				if (byte_s1 == 8'h00) begin
					stop_n = 1'b1;
				end else begin
					acc_n  = {24'b0, byte_s1};
					len_n  = 3'd1;
					pend_n = 1'b1;
				end
			end
		end

		fin_b = last_s1 && pend_n && !stop_n;
		cp_b  = acc_n - len_offset(len_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			len_q  <= '0;
			pend_q <= 1'b0;
			stop_q <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				acc_q  <= '0;
				len_q  <= '0;
				pend_q <= 1'b0;
				stop_q <= 1'b0;
			end else begin
				acc_q  <= acc_n;
				len_q  <= len_n;
				pend_q <= pend_n;
				stop_q <= stop_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_valid <= 1'b0;
		end else if (dec_ready) begin
			dec_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			dec_word.cp_a <= cp_a;
			dec_word.ok_a <= fin_a && !zero_a;
			dec_word.cp_b <= cp_b;
			dec_word.ok_b <= fin_b && (cp_b != 32'h0);
			dec_word.last <= last_s1;
		end
	end

endmodule

@@ src/utf8m_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8m_classify
// Range match of both code point slots against the right-to-left list.
// ----------------------------------------------------------------------------
module utf8m_classify
	import utf8m_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic dec_valid,
	input  dec_t dec_word,
	output logic dec_ready,
	input  logic cls_ready,
	output logic cls_valid,
	output cls_t cls_word
);

	assign dec_ready = !dec_valid || cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid <= 1'b0;
		end else if (cls_ready) begin
			cls_valid <= dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_valid && cls_ready) begin
			cls_word.ok_a  <= dec_word.ok_a;
			cls_word.rtl_a <= in_rtl(dec_word.cp_a);
			cls_word.ok_b  <= dec_word.ok_b;
			cls_word.rtl_b <= in_rtl(dec_word.cp_b);
			cls_word.last  <= dec_word.last;
		end
	end

endmodule

@@ src/utf8m_tally.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8m_tally
// Saturating character and right-to-left counters, and the result register
// loaded at the end of each string.
// ----------------------------------------------------------------------------
module utf8m_tally
	import utf8m_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cls_valid,
	input  cls_t                cls_word,
	output logic                cls_ready,
	output logic                rtl_majority,
	output logic [OUT_BITS-1:0] rtl_count,
	output logic [OUT_BITS-1:0] char_count,
	output logic                result_valid,
	input  logic                result_stall
);

	localparam logic [COUNT_BITS:0] CNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

	logic [COUNT_BITS-1:0] char_q;
	logic [COUNT_BITS-1:0] rtl_q;
	logic [COUNT_BITS-1:0] char_n;
	logic [COUNT_BITS-1:0] rtl_n;
	logic [1:0]            inc_c;
	logic [1:0]            inc_r;
	logic [COUNT_BITS:0]   sum_c;
	logic [COUNT_BITS:0]   sum_r;
	logic                  fire;

	assign cls_ready = !cls_valid || !cls_word.last || !result_valid || !result_stall;
	assign fire      = cls_valid && cls_ready;

	always_comb begin
		inc_c = {1'b0, cls_word.ok_a} + {1'b0, cls_word.ok_b};
		inc_r = {1'b0, cls_word.ok_a && cls_word.rtl_a}
		      + {1'b0, cls_word.ok_b && cls_word.rtl_b};
		sum_c = {1'b0, char_q} + (COUNT_BITS + 1)'(inc_c);
		sum_r = {1'b0, rtl_q} + (COUNT_BITS + 1)'(inc_r);
		char_n = (sum_c > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : sum_c[COUNT_BITS-1:0];
		rtl_n  = (sum_r > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : sum_r[COUNT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0;
			rtl_q  <= '0;
		end else if (fire) begin
			if (cls_word.last) begin
				char_q <= '0;
				rtl_q  <= '0;
			end else begin
				char_q <= char_n;
				rtl_q  <= rtl_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (fire && cls_word.last) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cls_word.last) begin
			rtl_majority <= (rtl_n > (char_n >> 1));
			rtl_count    <= OUT_BITS'(rtl_n);
			char_count   <= OUT_BITS'(char_n);
		end
	end

endmodule

@@ src/utf8_rtl_majority_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_rtl_majority_detector
// Counts code points of a UTF-8 byte stream and flags right-to-left majority.
// Path to the result: input, decoder and classifier registers, then result.
// Throughput: one byte per cycle; stalls only while a result is held back.
// Reset: arst_n clears all valid bits, decoder state and counters at once.
// ----------------------------------------------------------------------------
module utf8_rtl_majority_detector
	import utf8m_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                last,
	input  logic                byte_valid,
	output logic                byte_stall,
	output logic                rtl_majority,
	output logic [OUT_BITS-1:0] rtl_count,
	output logic [OUT_BITS-1:0] char_count,
	output logic                result_valid,
	input  logic                result_stall
);

	logic dec_valid;
	logic dec_ready;
	dec_t dec_word;
	logic cls_valid;
	logic cls_ready;
	cls_t cls_word;

	utf8m_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.last       (last),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.dec_ready  (dec_ready),
		.dec_valid  (dec_valid),
		.dec_word   (dec_word)
	);

	utf8m_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec_valid (dec_valid),
		.dec_word  (dec_word),
		.dec_ready (dec_ready),
		.cls_ready (cls_ready),
		.cls_valid (cls_valid),
		.cls_word  (cls_word)
	);

	utf8m_tally u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.cls_valid    (cls_valid),
		.cls_word     (cls_word),
		.cls_ready    (cls_ready),
		.rtl_majority (rtl_majority),
		.rtl_count    (rtl_count),
		.char_count   (char_count),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

@@ src/utf8m_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8m_checker
// Port-level checks of the detector: result hold, count consistency and input stall.
// ----------------------------------------------------------------------------
module utf8m_checker
	import utf8m_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input logic                rtl_majority,
	input logic [OUT_BITS-1:0] rtl_count,
	input logic [OUT_BITS-1:0] char_count,
	input logic                result_valid,
	input logic                result_stall
);

	localparam logic EXACT = (COUNT_BITS <= OUT_BITS);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(rtl_count)
			&& $stable(char_count) && $stable(rtl_majority))
		else $error("result word changed while stalled");

	a_rtl_le_char: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && EXACT |-> rtl_count <= char_count)
		else $error("rtl count exceeds char count");

	a_majority: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && EXACT |-> rtl_majority == (rtl_count > (char_count >> 1)))
		else $error("majority flag disagrees with counts");

	a_byte_stall: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> $past(byte_valid) || $past(byte_stall) || $past(result_stall))
		else $error("input stalled with no pending work");

endmodule

bind utf8_rtl_majority_detector utf8m_checker u_checker (.*);
